### rtl/core/heading_turn_controller_core_defines.svh
// Assertion macros for the heading turn controller.
`ifndef HEADING_TURN_CONTROLLER_CORE_DEFINES_SVH
`define HEADING_TURN_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define HTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define HTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/htc_pkg.sv
`timescale 1ns / 1ps

package htc_pkg;

	localparam int unsigned FULL_TURN = 360;
	localparam int unsigned HALF_TURN = FULL_TURN / 2;

	localparam int HEAD_W   = 9;
	localparam int TARGET_W = 16;
	localparam int ERR_W    = 8;
	localparam int SPEED_W  = 6;
	localparam int ACT_W    = 2;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	// request kinds
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// motor commands
	localparam logic [ACT_W-1:0] ACT_IDLE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TURN  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BRAKE = 2'd2;

	localparam logic [ERR_W-1:0]   DEADBAND  = 8'd3;
	localparam logic [ERR_W-1:0]   SAT_ERR   = 8'd62;   // first error whose speed exceeds max
	localparam logic [SPEED_W-1:0] SPEED_MIN = 6'd12;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 6'd50;

	// err*38/60 as (err * 38 * 2185) >> 17, exact for err below SAT_ERR
	localparam int SPD_SHIFT = 17;
	localparam int SPD_PROD_W = 25;
	localparam logic [SPD_PROD_W-1:0] SPD_RECIP = 25'd83030;

	// target wrap: add a multiple of 360 to make it non-negative, then
	// floor(u/360) ~ (u * 2912) >> 20, low by at most one
	localparam int WRAP_U_W     = 17;
	localparam int WRAP_PROD_W  = 29;
	localparam int WRAP_SHIFT   = 20;
	localparam int WRAP_Q_W     = 8;
	localparam logic [17:0] WRAP_OFFSET = 18'd33120;

endpackage

### rtl/core/htc_goal_wrap.sv
`timescale 1ns / 1ps

module htc_goal_wrap
	import htc_pkg::*;
(
	input  logic signed [TARGET_W-1:0] target,
	output logic        [HEAD_W-1:0]   goal
);

	logic [17:0]            u_ext;
	logic [WRAP_U_W-1:0]    u;
	logic [WRAP_PROD_W-1:0] u_w;
	logic [WRAP_PROD_W-1:0] prod;
	logic [WRAP_Q_W-1:0]    q;
	logic [WRAP_U_W-1:0]    q_w;
	logic [WRAP_U_W-1:0]    qm;
	logic [WRAP_U_W-1:0]    diff;
	logic [9:0]             r;
	logic [9:0]             r_sub;

	assign u_ext = {{2{target[TARGET_W-1]}}, target} + WRAP_OFFSET;
	assign u     = u_ext[WRAP_U_W-1:0];
	assign u_w   = {{(WRAP_PROD_W-WRAP_U_W){1'b0}}, u};

	// u * 2912
	assign prod = (u_w << 11) + (u_w << 9) + (u_w << 8) + (u_w << 6) + (u_w << 5);
	assign q    = prod[WRAP_SHIFT+WRAP_Q_W-1:WRAP_SHIFT];

	// q * 360
	assign q_w  = {{(WRAP_U_W-WRAP_Q_W){1'b0}}, q};
	assign qm   = (q_w << 8) + (q_w << 6) + (q_w << 5) + (q_w << 3);
	assign diff = u - qm;
	assign r    = diff[9:0];

	assign r_sub = r - 10'(FULL_TURN);
	assign goal  = (r >= 10'(FULL_TURN)) ? r_sub[HEAD_W-1:0] : r[HEAD_W-1:0];

endmodule

### rtl/core/heading_turn_controller_core.sv
`timescale 1ns / 1ps
`include "heading_turn_controller_core_defines.svh"

// Heading turn controller. Takes one item per clock, back to back, while the
// result register is not stalled, and returns exactly one result item per input
// item, in order, through the input register and then the result register. The
// target is reduced modulo 360 in front of the input register; error, direction
// and speed are worked out between the two registers. The goal and direction
// are updated as a start passes into the result register and the active flag as
// each item does, so a sample straight after a start sees the new goal. A stalled
// result register still lets the input register take one more item.
module heading_turn_controller_core
	import htc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [15:0] target_heading, [24:16] current_heading, [31:25] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic                  s_axis_tuser,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [1:0] motor_action, [2] turn_right, [8:3] turn_speed,
	// [16:9] heading_error, [23:17] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic              in_acc;
	logic              adv;
	logic              out_free;
	logic [HEAD_W-1:0] goal_in;

	logic              valid_s1;
	logic              kind_s1;
	logic [HEAD_W-1:0] goal_s1;
	logic [HEAD_W-1:0] cur_s1;

	logic              out_valid_q;
	logic [ACT_W-1:0]  action_q;
	logic              right_out_q;
	logic [SPEED_W-1:0] speed_q;
	logic [ERR_W-1:0]  err_q;

	logic [HEAD_W-1:0] goal_q;
	logic              right_q;
	logic              active_q;

	logic              is_start;
	logic [HEAD_W-1:0] goal_eff;
	logic [HEAD_W:0]   diff_gc;
	logic [HEAD_W-1:0] dist_abs;
	logic [HEAD_W+1:0] diff_wrap;
	logic [HEAD_W-1:0] dist_wrap;
	logic [ERR_W-1:0]  err;
	logic [HEAD_W:0]   cur_plus;
	logic [HEAD_W-1:0] cur_minus;
	logic              right_new;
	logic              right_eff;
	logic              active_eff;
	logic              far;
	logic [SPD_PROD_W-1:0] spd_prod;
	logic [SPEED_W-1:0] spd_lin;
	logic [SPEED_W-1:0] speed;
	logic [ACT_W-1:0]  action;

	htc_goal_wrap u_goal_wrap (
		.target (s_axis_tdata[TARGET_W-1:0]),
		.goal   (goal_in)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// wrap-aware error against the goal in force for this item
	assign is_start  = (kind_s1 == REQ_START);
	assign goal_eff  = is_start ? goal_s1 : goal_q;
	assign diff_gc   = {1'b0, goal_eff} - {1'b0, cur_s1};
	assign dist_abs  = diff_gc[HEAD_W] ? HEAD_W'(-diff_gc) : diff_gc[HEAD_W-1:0];
	assign diff_wrap = {2'b00, dist_abs} - (HEAD_W+2)'(FULL_TURN);
	assign dist_wrap = diff_wrap[HEAD_W+1] ? HEAD_W'(-diff_wrap) : diff_wrap[HEAD_W-1:0];
	assign err       = (dist_abs < dist_wrap) ? dist_abs[ERR_W-1:0] : dist_wrap[ERR_W-1:0];

	// shorter way from current to goal, decided on start only
	assign cur_plus  = {1'b0, cur_s1} + (HEAD_W+1)'(HALF_TURN);
	assign cur_minus = cur_s1 - HEAD_W'(HALF_TURN);
	always_comb begin
		if (cur_plus > (HEAD_W+1)'(FULL_TURN)) begin
			right_new = (goal_s1 >= cur_s1) || (goal_s1 < cur_minus);
		end else begin
			right_new = (goal_s1 >= cur_s1) && ({1'b0, goal_s1} <= cur_plus);
		end
	end
	assign right_eff  = is_start ? right_new : right_q;
	assign active_eff = is_start || active_q;

	assign far      = (err > DEADBAND);
	assign spd_prod = {{(SPD_PROD_W-ERR_W){1'b0}}, err} * SPD_RECIP;
	assign spd_lin  = spd_prod[SPD_SHIFT+SPEED_W-1:SPD_SHIFT] + SPEED_MIN;

	always_comb begin
		action = ACT_IDLE;
		speed  = '0;
		if (active_eff) begin
			if (far) begin
				action = ACT_TURN;
				speed  = (err >= SAT_ERR) ? SPEED_MAX : spd_lin;
			end else begin
				action = ACT_BRAKE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			goal_q      <= '0;
			right_q     <= 1'b0;
			active_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (is_start) begin
					goal_q  <= goal_s1;
					right_q <= right_new;
				end
				active_q <= active_eff && far;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= s_axis_tuser;
			goal_s1 <= goal_in;
			cur_s1  <= s_axis_tdata[TARGET_W+HEAD_W-1:TARGET_W];
		end
		if (adv) begin
			action_q    <= action;
			right_out_q <= right_eff;
			speed_q     <= speed;
			err_q       <= err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-ACT_W-1-SPEED_W-ERR_W){1'b0}},
		err_q, speed_q, right_out_q, action_q};

	`HTC_ASSERT_NOW(a_turn_speed_range, out_valid_q && action_q == ACT_TURN,
		speed_q >= SPEED_MIN && speed_q <= SPEED_MAX, "turn speed out of range")
	`HTC_ASSERT_NOW(a_no_speed_unless_turn, out_valid_q && action_q != ACT_TURN,
		speed_q == '0, "speed without a turn command")
	`HTC_ASSERT_NOW(a_err_range, out_valid_q, err_q <= ERR_W'(HALF_TURN),
		"heading error above half turn")
	`HTC_ASSERT_NEXT(a_brake_disarms, adv && action == ACT_BRAKE, !active_q,
		"control still armed after brake")
	`HTC_ASSERT_NOW(a_goal_in_range, 1'b1, goal_q < HEAD_W'(FULL_TURN),
		"stored goal outside a full turn")

endmodule
